// File: rtl/cts_pkg.sv
// Shared constants, types and codes for the text console cursor/scroll unit.
// Used by every module of the block; no dependencies.
package cts_pkg;

    localparam int ROWS = 25;
    localparam int COLS = 80;
    localparam int CELLS = ROWS * COLS;

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS + 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = 16;
    localparam int CMP_ROW_W = 7;
    localparam int CMP_COL_W = 8;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_TEXT_COLOR = '0;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam logic [7:0] RESET_COLOR = 8'h0F;

    localparam logic [1:0] OP_PUT = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLS);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

    typedef enum logic [2:0] {
        AOP_HOLD,
        AOP_ZERO,
        AOP_INC,
        AOP_LOAD,
        AOP_LASTROW
    } t_addr_op;

    typedef struct packed {
        t_addr_op          op;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_addr_ctl;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] addr_up;
        logic              copy_last;
        logic              cell_last;
    } t_addr_sts;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_ram_wr;

endpackage

// File: rtl/cts_if.sv
// Valid/ready channel interfaces for command transactions and result transactions.
// Depends on nothing.
interface cts_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, opcode, char_code, read_row, read_col, input ready);
    modport sink (input valid, opcode, char_code, read_row, read_col, output ready);
endinterface

interface cts_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_color;

    modport source (output valid, cursor_row, cursor_col, cell_char, cell_color, input ready);
    modport sink (input valid, cursor_row, cursor_col, cell_char, cell_color, output ready);
endinterface

// File: rtl/cts_apb_regs.sv
// APB-style register port holding the text colour attribute.
// Depends on cts_pkg.
module cts_apb_regs import cts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [7:0]         o_text_color
);

    logic [7:0] r_text_color;
    logic       reg_hit;

    assign reg_hit = paddr[PADDR_W-1:2] == REG_TEXT_COLOR;
    assign pready = 1'b1;
    assign prdata = reg_hit ? {{(PDATA_W-8){1'b0}}, r_text_color} : '0;
    assign o_text_color = r_text_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_COLOR;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_text_color <= pwdata[7:0];
        end
    end

endmodule

// File: rtl/cts_cell_ram.sv
// Screen cell store: one write port, one registered read port.
// Depends on cts_pkg.
module cts_cell_ram import cts_pkg::*; (
    input  logic              i_clk,
    input  t_ram_wr           i_wr,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/cts_addr_unit.sv
// Shared cell address unit: row*COLS+col load, step, and sweep end flags.
// Depends on cts_pkg.
module cts_addr_unit import cts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_addr_ctl i_ctl,
    output t_addr_sts o_sts
);

    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;

    always_comb begin
        case (i_ctl.op)
            AOP_ZERO:    n_addr = '0;
            AOP_INC:     n_addr = r_addr + 1'b1;
            AOP_LOAD:    n_addr = ADDR_W'(ADDR_W'(i_ctl.row) * ADDR_W'(COLS))
                                  + ADDR_W'(i_ctl.col);
            AOP_LASTROW: n_addr = LAST_ROW_BASE;
            default:     n_addr = r_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else begin
            r_addr <= n_addr;
        end
    end

    assign o_sts.addr = r_addr;
    assign o_sts.addr_up = r_addr + ADDR_W'(COLS);
    assign o_sts.copy_last = r_addr == COPY_LAST;
    assign o_sts.cell_last = r_addr == CELL_LAST;

endmodule

// File: rtl/cts_seq.sv
// Sequencer: cursor, put/clear/read/scroll steps, cell sweeps and result register.
// Depends on cts_pkg and cts_if; drives cts_addr_unit and cts_cell_ram.
module cts_seq import cts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_text_color,
    cts_in_if.sink            in_ch,
    cts_out_if.source         out_ch,
    output t_addr_ctl         o_addr_ctl,
    input  t_addr_sts         i_addr_sts,
    output t_ram_wr           o_ram_wr,
    output logic [ADDR_W-1:0] o_ram_raddr,
    input  logic [CELL_W-1:0] i_ram_rdata
);

    typedef enum logic [9:0] {
        S_IDLE       = 10'b0000000001,
        S_DECODE     = 10'b0000000010,
        S_ADDR       = 10'b0000000100,
        S_WRITE      = 10'b0000001000,
        S_RD_ISSUE   = 10'b0000010000,
        S_RD_WAIT    = 10'b0000100000,
        S_SCROLL     = 10'b0001000000,
        S_SCROLL_END = 10'b0010000000,
        S_FILL       = 10'b0100000000,
        S_RESP       = 10'b1000000000
    } t_state;

    t_state            r_state;
    logic [1:0]        r_op;
    logic [7:0]        r_ch;
    logic [4:0]        r_rrow;
    logic [6:0]        r_rcol;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic              r_pend_chr;
    logic              r_init;
    logic [7:0]        r_fill_color;
    logic              r_cp_pend;
    logic [ADDR_W-1:0] r_cp_addr;
    logic [CELL_W-1:0] r_cell;
    logic              r_out_valid;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [7:0]        r_out_char;
    logic [7:0]        r_out_color;

    logic rd_in_range;
    logic nl_needed;
    logic printable;
    logic on_last_row;

    assign rd_in_range = (CMP_ROW_W'(r_rrow) < CMP_ROW_W'(ROWS))
                      && (CMP_COL_W'(r_rcol) < CMP_COL_W'(COLS));
    assign printable = r_ch != NEWLINE_CODE;
    assign nl_needed = !printable || (r_col == COL_W'(COLS));
    assign on_last_row = r_row == ROW_W'(ROWS - 1);

    assign in_ch.ready = r_state == S_IDLE;
    assign out_ch.valid = r_out_valid;
    assign out_ch.cursor_row = 5'(r_out_row);
    assign out_ch.cursor_col = 7'(r_out_col);
    assign out_ch.cell_char = r_out_char;
    assign out_ch.cell_color = r_out_color;

    always_comb begin
        o_addr_ctl.op = AOP_HOLD;
        o_addr_ctl.row = r_row;
        o_addr_ctl.col = r_col;
        unique case (r_state)
            S_DECODE: begin
                if (r_op == OP_READ && rd_in_range) begin
                    o_addr_ctl.op = AOP_LOAD;
                    o_addr_ctl.row = ROW_W'(r_rrow);
                    o_addr_ctl.col = COL_W'(r_rcol);
                end else if (r_op == OP_CLEAR
                             || (r_op == OP_PUT && nl_needed && on_last_row)) begin
                    o_addr_ctl.op = AOP_ZERO;
                end
            end
            S_ADDR:       o_addr_ctl.op = AOP_LOAD;
            S_SCROLL:     o_addr_ctl.op = i_addr_sts.copy_last ? AOP_HOLD : AOP_INC;
            S_SCROLL_END: o_addr_ctl.op = AOP_LASTROW;
            S_FILL:       o_addr_ctl.op = i_addr_sts.cell_last ? AOP_HOLD : AOP_INC;
            default:      o_addr_ctl.op = AOP_HOLD;
        endcase
    end

    always_comb begin
        o_ram_wr.we = 1'b0;
        o_ram_wr.addr = i_addr_sts.addr;
        o_ram_wr.data = {r_fill_color, SPACE_CODE};
        if (r_state == S_FILL) begin
            o_ram_wr.we = 1'b1;
        end else if (r_cp_pend) begin
            o_ram_wr.we = 1'b1;
            o_ram_wr.addr = r_cp_addr;
            o_ram_wr.data = i_ram_rdata;
        end else if (r_state == S_WRITE) begin
            o_ram_wr.we = 1'b1;
            o_ram_wr.data = {i_text_color, r_ch};
        end
    end

    assign o_ram_raddr = (r_state == S_SCROLL) ? i_addr_sts.addr_up : i_addr_sts.addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_init <= 1'b1;
            r_fill_color <= RESET_COLOR;
            r_row <= '0;
            r_col <= '0;
            r_pend_chr <= 1'b0;
            r_cp_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cp_pend <= r_state == S_SCROLL;
            r_cp_addr <= i_addr_sts.addr;
            if (r_out_valid && out_ch.ready && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_op <= in_ch.opcode;
                        r_ch <= in_ch.char_code;
                        r_rrow <= in_ch.read_row;
                        r_rcol <= in_ch.read_col;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_cell <= '0;
                    unique case (r_op)
                        OP_PUT: begin
                            r_pend_chr <= printable;
                            if (nl_needed) begin
                                r_col <= '0;
                                if (on_last_row) begin
                                    r_fill_color <= i_text_color;
                                    r_state <= S_SCROLL;
                                end else begin
                                    r_row <= r_row + 1'b1;
                                    r_state <= printable ? S_ADDR : S_RESP;
                                end
                            end else begin
                                r_state <= S_ADDR;
                            end
                        end
                        OP_CLEAR: begin
                            r_row <= '0;
                            r_col <= '0;
                            r_pend_chr <= 1'b0;
                            r_fill_color <= i_text_color;
                            r_state <= S_FILL;
                        end
                        OP_READ: r_state <= rd_in_range ? S_RD_ISSUE : S_RESP;
                        default: r_state <= S_RESP;
                    endcase
                end
                S_ADDR: r_state <= S_WRITE;
                S_WRITE: begin
                    r_col <= r_col + 1'b1;
                    r_pend_chr <= 1'b0;
                    r_state <= S_RESP;
                end
                S_RD_ISSUE: r_state <= S_RD_WAIT;
                S_RD_WAIT: begin
                    r_cell <= i_ram_rdata;
                    r_state <= S_RESP;
                end
                S_SCROLL: begin
                    if (i_addr_sts.copy_last) begin
                        r_state <= S_SCROLL_END;
                    end
                end
                S_SCROLL_END: r_state <= S_FILL;
                S_FILL: begin
                    if (i_addr_sts.cell_last) begin
                        r_init <= 1'b0;
                        if (r_init) begin
                            r_state <= S_IDLE;
                        end else if (r_pend_chr) begin
                            r_state <= S_ADDR;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || out_ch.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_row <= r_row;
                        r_out_col <= r_col;
                        r_out_char <= r_cell[7:0];
                        r_out_color <= r_cell[15:8];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/text_console_cursor_scroll_unit.sv
// Top level of the text console cursor/scroll unit.
// Depends on cts_pkg, cts_if, cts_apb_regs, cts_cell_ram, cts_addr_unit, cts_seq.
//
// channel  dir  handshake        contents
// in_ch    in   valid/ready      opcode, char_code, read_row, read_col
// out_ch   out  valid/ready      cursor_row, cursor_col, cell_char, cell_color
// apb      in   psel/penable     paddr, pwdata, pwrite -> prdata, pready
//
// Put of a printable byte: decode, address, write, result; newline without scroll: decode,
// result; read: decode, issue, wait, result; clear: fill, result. A scroll adds an upward
// copy and a last-row fill, as the single RAM write port sweeps one cell a cycle. After
// reset a clearing pass runs with in_ch.ready low; register writes are taken meanwhile.
// A result waiting on out_ch does not block the next command; that command's result
// holds in the sequencer until the output register drains.
module text_console_cursor_scroll_unit import cts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cts_in_if.sink             in_ch,
    cts_out_if.source          out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [7:0]        text_color;
    t_addr_ctl         addr_ctl;
    t_addr_sts         addr_sts;
    t_ram_wr           ram_wr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    cts_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_text_color (text_color)
    );

    cts_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cts_addr_unit u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (addr_ctl),
        .o_sts   (addr_sts)
    );

    cts_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (text_color),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_addr_ctl   (addr_ctl),
        .i_addr_sts   (addr_sts),
        .o_ram_wr     (ram_wr),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input still ready after a transaction");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (32'(out_ch.cursor_col) <= 32'(COLS)))
        else $error("cursor column beyond wrap position");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (32'(out_ch.cursor_row) < 32'(ROWS)))
        else $error("cursor row beyond last row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid
        && $stable({out_ch.cursor_row, out_ch.cursor_col, out_ch.cell_char,
                    out_ch.cell_color}))
        else $error("result transaction changed while waiting");

endmodule
